FILE: src/assert_macros.svh
// Assertion macros used by the RTL of the guided target classifier.
// Depends on nothing; expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also runs during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/gtc_pkg.sv
// Types and constants of the guided target classifier.
// Used by gtc_eval, guided_target_classifier_core and the testbench; no dependencies.
package gtc_pkg;

    localparam int COORD_W = 24;
    localparam int CLASS_W = 4;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SQ_THR_W   = 2 * CFG_DATA_W;

    // item modes
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POSITION = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEST     = 2'd2;

    // target classes
    localparam logic [CLASS_W-1:0] CLS_NONE     = 4'd0;
    localparam logic [CLASS_W-1:0] CLS_POSITION = 4'd1;
    localparam logic [CLASS_W-1:0] CLS_MERGE    = 4'd2;
    localparam logic [CLASS_W-1:0] CLS_TERRAIN  = 4'd3;
    localparam logic [CLASS_W-1:0] CLS_FIRST    = 4'd4;
    localparam logic [CLASS_W-1:0] CLS_HORIZ    = 4'd5;
    localparam logic [CLASS_W-1:0] CLS_VERT     = 4'd6;
    localparam logic [CLASS_W-1:0] CLS_BOTH     = 4'd7;
    localparam logic [CLASS_W-1:0] CLS_SMALL    = 4'd8;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HORIZ_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERT_MIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_MIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MERGE_MAX = 2'd3;

    // reset thresholds, squared where compared as squares
    localparam logic [SQ_THR_W-1:0]   RST_HORIZ_SQ = 32'd10000;
    localparam logic [CFG_DATA_W-1:0] RST_VERT_MIN = 16'd100;
    localparam logic [SQ_THR_W-1:0]   RST_YAW_SQ   = 32'd40000;
    localparam logic [SQ_THR_W-1:0]   RST_MERGE_SQ = 32'd10000;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [COORD_W-1:0] new_north;
        logic signed [COORD_W-1:0] new_east;
        logic signed [COORD_W-1:0] new_down;
        logic                      new_terrain;
        logic                      current_present;
        logic signed [COORD_W-1:0] current_north;
        logic signed [COORD_W-1:0] current_east;
    } item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] north;
        logic signed [COORD_W-1:0] east;
        logic signed [COORD_W-1:0] down;
        logic                      terrain;
        logic                      valid;
        logic                      yaw_ok;
        logic [CLASS_W-1:0]        cls;
    } target_t;

    typedef struct packed {
        logic [SQ_THR_W-1:0]   horiz_sq;
        logic [CFG_DATA_W-1:0] vert_min;
        logic [SQ_THR_W-1:0]   yaw_sq;
        logic [SQ_THR_W-1:0]   merge_sq;
    } thr_t;

endpackage

FILE: src/gtc_eval.sv
// Next-target evaluation: squared distances, classification and update.
// Depends on gtc_pkg.
module gtc_eval
    import gtc_pkg::*;
(
    input  item_t   item,
    input  target_t held,
    input  thr_t    thr,
    output target_t next
);

    localparam int D2_W = 2 * COORD_W + 1;

    function automatic logic [COORD_W-1:0] mag_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] diff;
        logic [COORD_W:0]        m;
        diff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        m    = diff[COORD_W] ? (~diff + 1'b1) : diff;
        return m[COORD_W-1:0];
    endfunction

    function automatic logic [2*COORD_W-1:0] sq(input logic [COORD_W-1:0] a);
        return {{COORD_W{1'b0}}, a} * {{COORD_W{1'b0}}, a};
    endfunction

    logic [COORD_W-1:0] dn_held, de_held, dd_held, dn_cur, de_cur;
    logic [D2_W-1:0]    d2_held, d2_cur;
    logic comparable, is_h, is_v, is_yaw, dest_like, merge, first;

    always_comb
    begin
        dn_held = mag_diff(item.new_north, held.north);
        de_held = mag_diff(item.new_east, held.east);
        dd_held = mag_diff(item.new_down, held.down);
        dn_cur  = mag_diff(item.new_north, item.current_north);
        de_cur  = mag_diff(item.new_east, item.current_east);
        d2_held = {1'b0, sq(dn_held)} + {1'b0, sq(de_held)};
        d2_cur  = {1'b0, sq(dn_cur)} + {1'b0, sq(de_cur)};

        comparable = held.valid && !held.terrain && !item.new_terrain;
        is_h   = comparable && (d2_held >= {{(D2_W-SQ_THR_W){1'b0}}, thr.horiz_sq});
        is_yaw = comparable && (d2_held >= {{(D2_W-SQ_THR_W){1'b0}}, thr.yaw_sq});
        is_v   = comparable &&
                 (dd_held >= {{(COORD_W-CFG_DATA_W){1'b0}}, thr.vert_min});
        first  = !held.valid;

        case (held.cls) inside
            CLS_FIRST, CLS_HORIZ, CLS_VERT, CLS_BOTH, CLS_SMALL, CLS_MERGE:
                dest_like = 1'b1;
            default:
                dest_like = 1'b0;
        endcase

        merge = comparable && item.current_present && dest_like && is_v &&
                (d2_cur <= {{(D2_W-SQ_THR_W){1'b0}}, thr.merge_sq});

        next = held;
        unique case (item.mode)
            MODE_CLEAR:
            begin
                next = '0;
                next.cls = CLS_NONE;
            end
            MODE_POSITION:
            begin
                if (merge)
                begin
                    next.down = item.new_down;
                    next.cls  = CLS_MERGE;
                end
                else
                begin
                    next.north   = item.new_north;
                    next.east    = item.new_east;
                    next.down    = item.new_down;
                    next.terrain = item.new_terrain;
                    next.valid   = 1'b1;
                    next.yaw_ok  = 1'b0;
                    next.cls     = CLS_POSITION;
                end
            end
            MODE_DEST:
            begin
                next.yaw_ok = first ? !item.new_terrain : is_yaw;
                if (item.new_terrain || held.terrain)
                    next.cls = CLS_TERRAIN;
                else if (first)
                    next.cls = CLS_FIRST;
                else if (is_h && is_v)
                    next.cls = CLS_BOTH;
                else if (is_h)
                    next.cls = CLS_HORIZ;
                else if (is_v)
                    next.cls = CLS_VERT;
                else
                    next.cls = CLS_SMALL;
                next.north = item.new_north;
                next.east  = item.new_east;
                // horizontal-only move holds the old altitude
                if (!(is_h && !is_v))
                begin
                    next.down    = item.new_down;
                    next.terrain = item.new_terrain;
                    next.valid   = 1'b1;
                end
            end
            default:
            begin
                next = held;
            end
        endcase
    end

endmodule

FILE: src/guided_target_classifier_core.sv
// Guided target classifier top level: handshakes, thresholds, held target.
// Depends on gtc_pkg, gtc_eval and assert_macros.svh.
//
// Takes one item per clock cycle unless a stalled output holds the input register,
// and returns one result per item, in order. An accepted item sits in the input
// register until the output is free; it is then evaluated against the held target
// and loads the held target register, which is also the result register. The
// evaluation path lies between the input register and the held target: four
// 24x24 squarers, two adds and the threshold compares. Each result shows the
// held target after its item. A stalled output holds the input register; the
// input side keeps taking items while that register is free or draining.
// Config writes are taken in any cycle (cfg_ready is tied high) and are
// only meant while the block is idle; horizontal distance thresholds are
// squared at write time so the item path only compares. Index 0 horizontal
// min, 1 vertical min, 2 yaw min, 3 merge max, all in cm.
`include "assert_macros.svh"

module guided_target_classifier_core
    import gtc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [MODE_W-1:0]           mode,
    input  logic signed [COORD_W-1:0]   new_north,
    input  logic signed [COORD_W-1:0]   new_east,
    input  logic signed [COORD_W-1:0]   new_down,
    input  logic                        new_terrain,
    input  logic                        current_present,
    input  logic signed [COORD_W-1:0]   current_north,
    input  logic signed [COORD_W-1:0]   current_east,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [COORD_W-1:0]   held_north,
    output logic signed [COORD_W-1:0]   held_east,
    output logic signed [COORD_W-1:0]   held_down,
    output logic [CLASS_W-1:0]          target_class,
    output logic                        yaw_allowed,
    output logic                        held_valid,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    // input register
    item_t   s1_item_reg;
    logic    s1_valid_reg, s1_valid_next;
    // held target doubles as the result register
    target_t state_reg, state_next;
    logic    out_valid_reg, out_valid_next;
    thr_t    thr_reg, thr_next;

    logic in_accept, s1_adv, cfg_accept;
    logic [SQ_THR_W-1:0] cfg_sq;

    assign s1_adv     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_adv;
    assign in_accept  = in_valid && in_ready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    assign s1_valid_next  = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    gtc_eval u_eval (
        .item (s1_item_reg),
        .held (state_reg),
        .thr  (thr_reg),
        .next (state_next)
    );

    // thresholds compared as squares get squared here, once per write
    assign cfg_sq = {{CFG_DATA_W{1'b0}}, cfg_data} * {{CFG_DATA_W{1'b0}}, cfg_data};

    always_comb
    begin
        thr_next = thr_reg;
        if (cfg_accept)
        begin
            unique case (cfg_index)
                CFG_HORIZ_MIN: thr_next.horiz_sq = cfg_sq;
                CFG_VERT_MIN:  thr_next.vert_min = cfg_data;
                CFG_YAW_MIN:   thr_next.yaw_sq   = cfg_sq;
                CFG_MERGE_MAX: thr_next.merge_sq = cfg_sq;
                default:       thr_next = thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg.mode            <= mode;
            s1_item_reg.new_north       <= new_north;
            s1_item_reg.new_east        <= new_east;
            s1_item_reg.new_down        <= new_down;
            s1_item_reg.new_terrain     <= new_terrain;
            s1_item_reg.current_present <= current_present;
            s1_item_reg.current_north   <= current_north;
            s1_item_reg.current_east    <= current_east;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            // all zero, class none included
            state_reg         <= '0;
            thr_reg.horiz_sq  <= RST_HORIZ_SQ;
            thr_reg.vert_min  <= RST_VERT_MIN;
            thr_reg.yaw_sq    <= RST_YAW_SQ;
            thr_reg.merge_sq  <= RST_MERGE_SQ;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            thr_reg       <= thr_next;
            if (s1_adv)
                state_reg <= state_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign held_north   = state_reg.north;
    assign held_east    = state_reg.east;
    assign held_down    = state_reg.down;
    assign target_class = state_reg.cls;
    assign yaw_allowed  = state_reg.yaw_ok;
    assign held_valid   = state_reg.valid;

    // an item waiting on a stalled output stays in the input register
    `ASSERT_CLK(a_s1_hold, s1_valid_reg && !s1_adv |=> s1_valid_reg, "input item dropped")
    // held target only moves when an item is evaluated
    `ASSERT_CLK(a_state_stable, !s1_adv |=> $stable(state_reg), "held target moved")
    // valid flag is set exactly when the class is not none
    `ASSERT_CLK(a_valid_cls, state_reg.valid == (state_reg.cls != CLS_NONE), "valid/class")
    // yaw is never allowed on a position target
    `ASSERT_CLK(a_yaw_cls, state_reg.yaw_ok |-> state_reg.cls != CLS_POSITION, "yaw on position")

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for guided_target_classifier_core.
// Depends on gtc_pkg and the core RTL; a scoreboard class tracks the held
// target and checks every result, plain tasks drive items and threshold writes.
module testbench;
    import gtc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;   // no named code in the package
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;                   // receiver hold-off, cycles
    localparam int SETTLE_CYC  = 4;                     // margin after the last result drains

    // one result item: the held target as the block reports it
    typedef struct packed {
        logic signed [COORD_W-1:0] north;
        logic signed [COORD_W-1:0] east;
        logic signed [COORD_W-1:0] down;
        logic [CLASS_W-1:0]        cls;
        logic                      yaw_ok;
        logic                      valid;
    } held_t;

    // Tracks the held target and thresholds, queues the held target expected
    // after each accepted item and checks results in order.
    class held_target_tracker;
        logic signed [COORD_W-1:0] north, east, down;
        logic                      terrain, valid, yaw_ok;
        logic [CLASS_W-1:0]        cls;
        logic [CFG_DATA_W-1:0]     horiz_min, vert_min, yaw_min, merge_max;
        held_t                     expected_held[$];
        int                        mismatch_count;

        function new();
            horiz_min = 16'd100;
            vert_min  = 16'd100;
            yaw_min   = 16'd200;
            merge_max = 16'd100;
            mismatch_count = 0;
            clear_target();
        endfunction

        function void clear_target();
            north = '0;
            east = '0;
            down = '0;
            terrain = 1'b0;
            valid = 1'b0;
            yaw_ok = 1'b0;
            cls = CLS_NONE;
        endfunction

        function void write_threshold(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_HORIZ_MIN: horiz_min = val;
                CFG_VERT_MIN:  vert_min  = val;
                CFG_YAW_MIN:   yaw_min   = val;
                CFG_MERGE_MAX: merge_max = val;
                default: ;
            endcase
        endfunction

        function longint squared(logic [CFG_DATA_W-1:0] v);
            return longint'(v) * longint'(v);
        endfunction

        function longint sq_dist(longint an, longint ae, longint bn, longint be);
            longint dn, de;
            dn = an - bn;
            de = ae - be;
            return dn * dn + de * de;
        endfunction

        function int pending();
            return expected_held.size();
        endfunction

        // next held target from one accepted item
        function void predict_item(item_t it);
            longint n, e, d, cn, ce, dist_held, dz;
            logic   t, comp, horiz, vert, first, dest_like;
            held_t  nxt;
            n  = longint'($signed(it.new_north));
            e  = longint'($signed(it.new_east));
            d  = longint'($signed(it.new_down));
            cn = longint'($signed(it.current_north));
            ce = longint'($signed(it.current_east));
            t  = it.new_terrain;
            // distances only mean something between two non-terrain targets
            comp = valid && !terrain && !t;
            dist_held = sq_dist(n, e, longint'(north), longint'(east));
            dz = d - longint'(down);
            if (dz < 0)
                dz = -dz;
            horiz = comp && (dist_held >= squared(horiz_min));
            vert  = comp && (dz >= longint'(vert_min));
            case (it.mode)
                MODE_CLEAR: clear_target();
                MODE_POSITION:
                begin
                    dest_like = cls inside {CLS_FIRST, CLS_HORIZ, CLS_VERT, CLS_BOTH,
                                            CLS_SMALL, CLS_MERGE};
                    if (comp && it.current_present && dest_like && vert &&
                        sq_dist(n, e, cn, ce) <= squared(merge_max))
                    begin
                        // altitude merge: down and class only
                        down = it.new_down;
                        cls = CLS_MERGE;
                    end
                    else
                    begin
                        yaw_ok = 1'b0;
                        north = it.new_north;
                        east = it.new_east;
                        down = it.new_down;
                        terrain = t;
                        valid = 1'b1;
                        cls = CLS_POSITION;
                    end
                end
                MODE_DEST:
                begin
                    first = !valid;
                    yaw_ok = first ? !t : (comp && dist_held >= squared(yaw_min));
                    if (t || terrain)
                        cls = CLS_TERRAIN;
                    else if (first)
                        cls = CLS_FIRST;
                    else if (horiz && vert)
                        cls = CLS_BOTH;
                    else if (horiz)
                        cls = CLS_HORIZ;
                    else if (vert)
                        cls = CLS_VERT;
                    else
                        cls = CLS_SMALL;
                    north = it.new_north;
                    east = it.new_east;
                    // horizontal-only move keeps altitude and terrain flag
                    if (!(horiz && !vert))
                    begin
                        down = it.new_down;
                        terrain = t;
                        valid = 1'b1;
                    end
                end
                default: ;
            endcase
            nxt.north = north;
            nxt.east = east;
            nxt.down = down;
            nxt.cls = cls;
            nxt.yaw_ok = yaw_ok;
            nxt.valid = valid;
            expected_held.push_back(nxt);
        endfunction

        function void cmp_field(string name, longint want, longint got);
            if (want != got)
            begin
                mismatch_count++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_held(held_t got);
            held_t want;
            if (expected_held.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result with no item outstanding, actual %h", $time, got);
                return;
            end
            want = expected_held.pop_front();
            cmp_field("held_north", longint'(want.north), longint'(got.north));
            cmp_field("held_east", longint'(want.east), longint'(got.east));
            cmp_field("held_down", longint'(want.down), longint'(got.down));
            cmp_field("target_class", longint'(want.cls), longint'(got.cls));
            cmp_field("yaw_allowed", longint'(want.yaw_ok), longint'(got.yaw_ok));
            cmp_field("held_valid", longint'(want.valid), longint'(got.valid));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [MODE_W-1:0]         mode = MODE_CLEAR;
    logic signed [COORD_W-1:0] new_north = '0;
    logic signed [COORD_W-1:0] new_east = '0;
    logic signed [COORD_W-1:0] new_down = '0;
    logic                      new_terrain = 1'b0;
    logic                      current_present = 1'b0;
    logic signed [COORD_W-1:0] current_north = '0;
    logic signed [COORD_W-1:0] current_east = '0;

    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [COORD_W-1:0] held_north;
    logic signed [COORD_W-1:0] held_east;
    logic signed [COORD_W-1:0] held_down;
    logic [CLASS_W-1:0]        target_class;
    logic                      yaw_allowed;
    logic                      held_valid;

    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = CFG_HORIZ_MIN;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;

    held_target_tracker tracker = new();
    bit quiet = 1'b0;            // no idling on either side
    bit long_hold_req = 1'b0;    // ask the receiver for one long hold-off
    int cycle_count = 0;

    guided_target_classifier_core DUT (.*);

    initial
    begin
        forever #4 clk = ~clk;
    end

    // watchdog: a correct run ends far below the limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Result side. Inputs and outputs are both sampled at the rising edge,
    // before any nonblocking update lands, so ordering within a step is moot.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_held({held_north, held_east, held_down, target_class,
                                yaw_allowed, held_valid});
    end

    // Receiver: random ready/stall bursts, one long hold-off on request.
    // Exactly one nonblocking write to out_ready per pass, then time moves.
    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (quiet || $urandom_range(0, 3) != 0)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
        end
    end

    // Offer one item, optionally after an idle burst; valid is never
    // lowered between back-to-back items.
    task automatic send_item(item_t it);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        mode            <= it.mode;
        new_north       <= it.new_north;
        new_east        <= it.new_east;
        new_down        <= it.new_down;
        new_terrain     <= it.new_terrain;
        current_present <= it.current_present;
        current_north   <= it.current_north;
        current_east    <= it.current_east;
        do @(posedge clk); while (!in_ready);
        tracker.predict_item(it);
    endtask

    // Stop offering, let every result drain, then a little margin.
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        tracker.write_threshold(idx, val);
    endtask

    // Block must be idle; all four thresholds rewritten.
    task automatic load_thresholds(logic [CFG_DATA_W-1:0] h, logic [CFG_DATA_W-1:0] v,
                                   logic [CFG_DATA_W-1:0] y, logic [CFG_DATA_W-1:0] m);
        settle();
        cfg_write(CFG_HORIZ_MIN, h);
        cfg_write(CFG_VERT_MIN, v);
        cfg_write(CFG_YAW_MIN, y);
        cfg_write(CFG_MERGE_MAX, m);
        cfg_valid <= 1'b0;
    endtask

    function automatic item_t mk(logic [MODE_W-1:0] md, int n, int e, int d, bit t,
                                 bit cp, int cn, int ce);
        item_t it;
        it.mode = md;
        it.new_north = COORD_W'(n);
        it.new_east = COORD_W'(e);
        it.new_down = COORD_W'(d);
        it.new_terrain = t;
        it.current_present = cp;
        it.current_north = COORD_W'(cn);
        it.current_east = COORD_W'(ce);
        return it;
    endfunction

    // Coordinate near base, scaled to a threshold so the compares flip
    // often; now and then anywhere in the 24-bit range.
    function automatic logic [COORD_W-1:0] jitter(logic [COORD_W-1:0] base, int unsigned thr);
        int unsigned span;
        int          off;
        span = 0;
        off = 0;
        case ($urandom_range(0, 5))
            0: return COORD_W'($urandom);
            1: off = int'($urandom_range(0, 4)) - 2;
            2, 3:
            begin
                span = thr + thr / 4 + 2;
                off = int'($urandom_range(0, 2 * span)) - int'(span);
            end
            default:
            begin
                span = 3 * thr + 20;
                off = int'($urandom_range(0, 2 * span)) - int'(span);
            end
        endcase
        return COORD_W'(base + off);
    endfunction

    function automatic item_t random_item();
        item_t       it;
        int unsigned r, xy_thr;
        r = $urandom_range(0, 99);
        if (r < 4)
            it.mode = MODE_CLEAR;
        else if (r < 8)
            it.mode = MODE_UNUSED;
        else if (r < 45)
            it.mode = MODE_POSITION;
        else
            it.mode = MODE_DEST;
        case ($urandom_range(0, 2))
            0: xy_thr = 32'(tracker.horiz_min);
            1: xy_thr = 32'(tracker.yaw_min);
            default: xy_thr = 32'(tracker.merge_max);
        endcase
        it.new_north = jitter(tracker.north, xy_thr);
        it.new_east = jitter(tracker.east, xy_thr);
        it.new_down = jitter(tracker.down, 32'(tracker.vert_min));
        it.new_terrain = ($urandom_range(0, 9) == 0);
        it.current_present = ($urandom_range(0, 4) != 0);
        // current position around the new point, inside and outside merge range
        it.current_north = jitter(it.new_north, 32'(tracker.merge_max));
        it.current_east = jitter(it.new_east, 32'(tracker.merge_max));
        return it;
    endfunction

    task automatic run_items(int count);
        repeat (count) send_item(random_item());
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_thr();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return CFG_DATA_W'($urandom_range(0, 65535));
            default: return CFG_DATA_W'($urandom_range(1, 3000));
        endcase
    endfunction

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset thresholds (100, 100, 200, 100)
        send_item(mk(MODE_DEST, 0, 0, 0, 0, 1, 0, 0));             // first destination
        send_item(mk(MODE_DEST, 150, 0, 0, 0, 1, 0, 0));           // horizontal, altitude held
        send_item(mk(MODE_DEST, 150, 0, -500, 0, 0, 0, 0));        // vertical
        send_item(mk(MODE_DEST, 400, 300, 0, 0, 1, 9, 9));         // both, yaw allowed
        send_item(mk(MODE_DEST, 410, 300, 10, 0, 1, 0, 0));        // small
        send_item(mk(MODE_POSITION, 1000, 1000, -1000, 0, 1, 1000, 1050)); // merge
        send_item(mk(MODE_POSITION, 1000, 1000, 2000, 0, 0, 1000, 1000));  // no current pos
        send_item(mk(MODE_POSITION, 1000, 1010, 5000, 0, 1, 1000, 1000));  // not dest-like
        send_item(mk(MODE_DEST, 1200, 1000, 5000, 1, 1, 0, 0));    // terrain request
        send_item(mk(MODE_DEST, 5000, 5000, 0, 0, 1, 0, 0));       // stored terrain
        send_item(mk(MODE_UNUSED, -1, -1, -1, 1, 1, -1, -1));      // unused mode
        send_item(mk(MODE_CLEAR, 77, 77, 77, 1, 1, 77, 77));       // clear
        send_item(mk(MODE_DEST, 5, 5, 5, 1, 0, 0, 0));             // first on terrain
        send_item(mk(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(MODE_DEST, 8388607, 8388607, 8388607, 0, 1, 8388607, 8388607));
        send_item(mk(MODE_DEST, -8388608, -8388608, -8388608, 0, 1, -8388608, -8388608));
        send_item(mk(MODE_POSITION, -8388608, -8388608, 8388607, 0, 1, 8388607, 8388607));
        send_item(mk(MODE_DEST, 8388607, -8388608, 8388607, 1, 0, -8388608, 8388607));
        send_item(mk(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(MODE_DEST, 0, 0, 0, 0, 1, 0, 0));
        send_item(mk(MODE_POSITION, 0, 100, 100, 0, 1, 0, 0));     // merge right at both edges
        send_item(mk(MODE_POSITION, 0, 100, 199, 0, 1, 0, 100));   // vertical just short
        send_item(mk(MODE_DEST, 0, 200, 298, 0, 1, 0, 0));         // horizontal at edge
        send_item(mk(MODE_POSITION, 0, 200, 398, 0, 1, 0, 301));   // merge range just short

        // extremes first, then the reset values written back
        load_thresholds(16'd0, 16'd0, 16'd0, 16'd0);
        run_items(100);
        load_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_items(100);
        load_thresholds(16'd100, 16'd100, 16'd200, 16'd100);
        long_hold_req = 1'b1;   // fill the pipe against a stalled output
        run_items(200);

        repeat (6)
        begin
            load_thresholds(rand_thr(), rand_thr(), rand_thr(), rand_thr());
            run_items(190);
        end

        // closing stretch at full rate on both sides
        load_thresholds(rand_thr(), rand_thr(), rand_thr(), rand_thr());
        quiet = 1'b1;
        run_items(190);

        settle();
        repeat (8) @(posedge clk);
        if (tracker.mismatch_count == 0 && tracker.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
